// File: rtl/mccs_pkg.sv
package mccs_pkg;

  localparam int ELEM_W           = 16;
  localparam int CFG_W            = 4;
  localparam int SCORE_W          = 16;
  localparam int COL_OUT_W        = 3;
  localparam int SQ_W             = 2 * ELEM_W;
  // Register fields cap the rows at 15, so a sum of squares stays below 2^34.
  localparam int ACC_W            = 34;
  localparam int DOT_W            = ACC_W + 1;
  localparam int PROD_W           = 2 * ACC_W;
  localparam int QUO_W            = 31;
  localparam int ROOT_W           = 16;
  localparam int DEFAULT_MAX_ROWS = 8;
  localparam int DEFAULT_MAX_COLS = 8;

  typedef enum logic [0:0] {
    CFG_ROWS_IN_USE = 1'b0,
    CFG_COLS_IN_USE = 1'b1
  } cfg_reg_t;

endpackage

// File: rtl/max_column_cosine_similarity_core.sv
// Loads a gain matrix one signed Q3.12 word per cycle while busy is low, row by row, and
// after the last word scores every column pair by |dot| / (norm_i * norm_j) as unsigned
// Q1.15, reporting the best score and the earliest pair reaching it with a one-cycle
// out_valid strobe that cannot be stalled. Evaluation then holds busy high: each row of
// a pair needs two reads through the matrix store's single read port and a serial
// multiply, and each pair whose norms are both nonzero ends with serial products, a
// restoring divide and a square root. Writing a configuration register restarts the
// load from the first element.
module max_column_cosine_similarity_core #(
  parameter int MAX_ROWS = mccs_pkg::DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = mccs_pkg::DEFAULT_MAX_COLS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mccs_pkg::ELEM_W-1:0]   in_gain_value,
  input  logic                                 cfg_we,
  input  mccs_pkg::cfg_reg_t                   cfg_index,
  input  logic [mccs_pkg::CFG_W-1:0]           cfg_wdata,
  output logic                                 out_valid,
  output logic [mccs_pkg::SCORE_W-1:0]         out_max_cosine,
  output logic [mccs_pkg::COL_OUT_W-1:0]       out_first_column,
  output logic [mccs_pkg::COL_OUT_W-1:0]       out_second_column,
  output logic                                 out_pair_found
);

  import mccs_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int EW    = 7;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_I, S_RD_J, S_MUL_GO, S_MUL_WAIT,
    S_SCALE_GO, S_SCALE_WAIT, S_ROOT_WAIT, S_NEXT, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   rows_cfg_r, rows_cfg_nxt, cols_cfg_r, cols_cfg_nxt;
  logic [RW-1:0]      ld_row_r, ld_row_nxt, k_r, k_nxt;
  logic [CW-1:0]      ld_col_r, ld_col_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]      best_i_r, best_i_nxt, best_j_r, best_j_nxt;
  logic [ELEM_W-1:0]  vi_r, vi_nxt;
  logic               neg_r, neg_nxt;
  logic [ACC_W-1:0]   n2i_r, n2i_nxt, n2j_r, n2j_nxt;
  logic [DOT_W-1:0]   dot_r, dot_nxt;
  logic [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic               found_r, found_nxt;

  logic [ELEM_W-1:0]  gain_mem [DEPTH];
  logic [ELEM_W-1:0]  rdata_r;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic               mem_we;

  logic [EW-1:0]      eff_rows, eff_cols, rows_m1, cols_m1, cols_m2;
  logic [RW-1:0]      rows_last;
  logic [CW-1:0]      cols_last, cols_last2;

  logic [ELEM_W-1:0]  mag_i, mag_j;
  logic [DOT_W-1:0]   abs_dot_full;
  logic [ACC_W-1:0]   abs_dot;
  logic [SQ_W-1:0]    p_ii, p_jj, p_ij;
  logic               mii_done, mjj_done, mij_done;
  logic [PROD_W-1:0]  prod_p, prod_r;
  logic               mp_done, mr_done;
  logic [ROOT_W-1:0]  score;
  logic               root_done;
  logic               mul_go, scale_go, root_go, qualify;

  // Zero acts as one and anything beyond the build maximum acts as the maximum.
  always_comb begin
    eff_rows = (rows_cfg_r == '0) ? EW'(1) :
               ({3'b000, rows_cfg_r} > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : {3'b000, rows_cfg_r};
    eff_cols = (cols_cfg_r == '0) ? EW'(1) :
               ({3'b000, cols_cfg_r} > EW'(MAX_COLS)) ? EW'(MAX_COLS) : {3'b000, cols_cfg_r};
    rows_m1  = eff_rows - EW'(1);
    cols_m1  = eff_cols - EW'(1);
    cols_m2  = eff_cols - EW'(2);
  end

  assign rows_last  = rows_m1[RW-1:0];
  assign cols_last  = cols_m1[CW-1:0];
  assign cols_last2 = cols_m2[CW-1:0];

  assign wr_addr = AW'(ld_row_r * MAX_COLS + ld_col_r);
  assign rd_addr = (state_r == S_RD_I) ? AW'(k_r * MAX_COLS + i_r) : AW'(k_r * MAX_COLS + j_r);
  assign mem_we  = (state_r == S_IDLE) && start;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      gain_mem[wr_addr] <= in_gain_value;
    end
    rdata_r <= gain_mem[rd_addr];
  end

  assign mag_i = vi_r[ELEM_W-1] ? (~vi_r + 1'b1) : vi_r;
  assign mag_j = rdata_r[ELEM_W-1] ? (~rdata_r + 1'b1) : rdata_r;

  assign abs_dot_full = dot_r[DOT_W-1] ? (~dot_r + 1'b1) : dot_r;
  assign abs_dot      = abs_dot_full[ACC_W-1:0];

  assign qualify  = (n2i_r != '0) && (n2j_r != '0);
  assign mul_go   = (state_r == S_MUL_GO);
  assign scale_go = (state_r == S_SCALE_GO) && qualify;
  assign root_go  = (state_r == S_SCALE_WAIT) && mp_done;

  mccs_ser_mul #(.AW(ELEM_W), .BW(ELEM_W)) u_mul_ii (
    .clk, .rst_n, .start(mul_go), .a(mag_i), .b(mag_i), .prod(p_ii), .done(mii_done)
  );

  mccs_ser_mul #(.AW(ELEM_W), .BW(ELEM_W)) u_mul_jj (
    .clk, .rst_n, .start(mul_go), .a(mag_j), .b(mag_j), .prod(p_jj), .done(mjj_done)
  );

  mccs_ser_mul #(.AW(ELEM_W), .BW(ELEM_W)) u_mul_ij (
    .clk, .rst_n, .start(mul_go), .a(mag_i), .b(mag_j), .prod(p_ij), .done(mij_done)
  );

  mccs_ser_mul #(.AW(ACC_W), .BW(ACC_W)) u_mul_norm (
    .clk, .rst_n, .start(scale_go), .a(n2i_r), .b(n2j_r), .prod(prod_p), .done(mp_done)
  );

  mccs_ser_mul #(.AW(ACC_W), .BW(ACC_W)) u_mul_dot (
    .clk, .rst_n, .start(scale_go), .a(abs_dot), .b(abs_dot), .prod(prod_r), .done(mr_done)
  );

  mccs_root u_root (
    .clk, .rst_n, .start(root_go), .num(prod_r), .den(prod_p), .score(score), .done(root_done)
  );

  always_comb begin
    state_nxt      = state_r;
    rows_cfg_nxt   = rows_cfg_r;
    cols_cfg_nxt   = cols_cfg_r;
    ld_row_nxt     = ld_row_r;
    ld_col_nxt     = ld_col_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    vi_nxt         = vi_r;
    neg_nxt        = neg_r;
    n2i_nxt        = n2i_r;
    n2j_nxt        = n2j_r;
    dot_nxt        = dot_r;
    best_score_nxt = best_score_r;
    best_i_nxt     = best_i_r;
    best_j_nxt     = best_j_r;
    found_nxt      = found_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (ld_col_r == cols_last) begin
            ld_col_nxt = '0;
            if (ld_row_r == rows_last) begin
              // Last word of the matrix: start scoring.
              ld_row_nxt     = '0;
              k_nxt          = '0;
              i_nxt          = '0;
              j_nxt          = CW'(1);
              n2i_nxt        = '0;
              n2j_nxt        = '0;
              dot_nxt        = '0;
              best_score_nxt = '0;
              best_i_nxt     = '0;
              best_j_nxt     = '0;
              found_nxt      = 1'b0;
              state_nxt      = (cols_last == '0) ? S_DONE : S_RD_I;
            end else begin
              ld_row_nxt = ld_row_r + 1'b1;
            end
          end else begin
            ld_col_nxt = ld_col_r + 1'b1;
          end
        end
      end
      S_RD_I:   state_nxt = S_RD_J;
      S_RD_J: begin
        vi_nxt    = rdata_r;
        state_nxt = S_MUL_GO;
      end
      S_MUL_GO: begin
        neg_nxt   = vi_r[ELEM_W-1] ^ rdata_r[ELEM_W-1];
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mii_done && mjj_done && mij_done) begin
          n2i_nxt = n2i_r + ACC_W'(p_ii);
          n2j_nxt = n2j_r + ACC_W'(p_jj);
          dot_nxt = neg_r ? (dot_r - DOT_W'(p_ij)) : (dot_r + DOT_W'(p_ij));
          if (k_r == rows_last) begin
            state_nxt = S_SCALE_GO;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_RD_I;
          end
        end
      end
      S_SCALE_GO: state_nxt = qualify ? S_SCALE_WAIT : S_NEXT;
      S_SCALE_WAIT: begin
        if (mp_done && mr_done) begin
          state_nxt = S_ROOT_WAIT;
        end
      end
      S_ROOT_WAIT: begin
        if (root_done) begin
          // Strictly greater keeps the earliest pair on a tie.
          if (!found_r || (score > best_score_r)) begin
            best_score_nxt = score;
            best_i_nxt     = i_r;
            best_j_nxt     = j_r;
            found_nxt      = 1'b1;
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        k_nxt   = '0;
        n2i_nxt = '0;
        n2j_nxt = '0;
        dot_nxt = '0;
        if (j_r == cols_last) begin
          if (i_r == cols_last2) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r + 1'b1;
            j_nxt     = CW'(i_r + 2'd2);
            state_nxt = S_RD_I;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RD_I;
        end
      end
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_IN_USE: rows_cfg_nxt = cfg_wdata;
        CFG_COLS_IN_USE: cols_cfg_nxt = cfg_wdata;
        default: ;
      endcase
      ld_row_nxt = '0;
      ld_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rows_cfg_r   <= CFG_W'(8);
      cols_cfg_r   <= CFG_W'(8);
      ld_row_r     <= '0;
      ld_col_r     <= '0;
      best_score_r <= '0;
      best_i_r     <= '0;
      best_j_r     <= '0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rows_cfg_r   <= rows_cfg_nxt;
      cols_cfg_r   <= cols_cfg_nxt;
      ld_row_r     <= ld_row_nxt;
      ld_col_r     <= ld_col_nxt;
      best_score_r <= best_score_nxt;
      best_i_r     <= best_i_nxt;
      best_j_r     <= best_j_nxt;
      found_r      <= found_nxt;
    end
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    vi_r  <= vi_nxt;
    neg_r <= neg_nxt;
    n2i_r <= n2i_nxt;
    n2j_r <= n2j_nxt;
    dot_r <= dot_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_DONE);
  assign out_max_cosine    = best_score_r;
  assign out_first_column  = COL_OUT_W'(best_i_r);
  assign out_second_column = COL_OUT_W'(best_j_r);
  assign out_pair_found    = found_r;

endmodule

// File: rtl/mccs_ser_mul.sv
module mccs_ser_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] prod,
  output logic            done
);

  localparam int CNT_W = $clog2(BW + 1);

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] p_r, p_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [AW:0]      sum;

  // Shift-add: one multiplier bit leaves at the bottom each cycle.
  assign sum   = {1'b0, p_r[AW+BW-1:BW]} + (p_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});
  assign p_nxt = {sum, p_r[BW-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        p_r   <= {{AW{1'b0}}, b};
        cnt_r <= CNT_W'(BW);
      end else if (cnt_r != '0) begin
        p_r    <= p_nxt;
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign prod = p_r;
  assign done = done_r;

endmodule

// File: rtl/mccs_root.sv
module mccs_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mccs_pkg::PROD_W-1:0]   num,
  input  logic [mccs_pkg::PROD_W-1:0]   den,
  output logic [mccs_pkg::ROOT_W-1:0]   score,
  output logic                          done
);

  import mccs_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam int SR_W  = ROOT_W + 3;
  localparam int X_W   = 2 * ROOT_W;

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} root_state_t;

  root_state_t      state_r;
  logic [PROD_W:0]  rem_r;
  logic [PROD_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic [X_W-1:0]   x_r;
  logic [SR_W-1:0]  srem_r;
  logic [ROOT_W-1:0] root_r, score_r;
  logic             done_r;

  logic             div_ge;
  logic [PROD_W:0]  div_sel;
  logic [SR_W-1:0]  srem_in, trial;
  logic             sq_ge;

  // The quotient, num / den scaled by 2^30, never exceeds 2^30, so 31 quotient bits suffice.
  assign div_ge  = rem_r >= {1'b0, den_r};
  assign div_sel = div_ge ? (rem_r - {1'b0, den_r}) : rem_r;

  // Digit-by-digit square root, two radicand bits per cycle.
  assign srem_in = {srem_r[SR_W-3:0], x_r[X_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign sq_ge   = srem_in >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        R_IDLE: begin
          if (start) begin
            rem_r   <= {1'b0, num};
            den_r   <= den;
            cnt_r   <= '0;
            state_r <= R_DIV;
          end
        end
        R_DIV: begin
          rem_r <= {div_sel[PROD_W-1:0], 1'b0};
          quo_r <= {quo_r[QUO_W-2:0], div_ge};
          if (cnt_r == CNT_W'(QUO_W - 1)) begin
            x_r     <= X_W'({quo_r[QUO_W-2:0], div_ge});
            srem_r  <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= R_SQRT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        R_SQRT: begin
          srem_r <= sq_ge ? (srem_in - trial) : srem_in;
          root_r <= {root_r[ROOT_W-2:0], sq_ge};
          x_r    <= {x_r[X_W-3:0], 2'b00};
          if (cnt_r == CNT_W'(ROOT_W - 1)) begin
            score_r <= {root_r[ROOT_W-2:0], sq_ge};
            done_r  <= 1'b1;
            state_r <= R_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  assign score = score_r;
  assign done  = done_r;

endmodule
